### rtl/core/mgcov_pkg.sv
// ----------------------------------------------------------------------------
// mgcov_pkg
// shared types and constants of the two-asset garch(1,1) covariance recursion
// ----------------------------------------------------------------------------
package mgcov_pkg;

  localparam int unsigned RetW    = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned CovW    = 32;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ProdW   = CoefW + CovW;
  localparam int unsigned AccW    = ProdW + 2;
  localparam int unsigned FracDrop = 14;
  localparam int unsigned CAlign  = 24;
  localparam int unsigned RndW    = AccW - FracDrop;

  localparam logic [CfgIdxW-1:0] CfgIdxC = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxA = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxB = 2'd2;

  localparam logic [CfgW-1:0] CResetVal = 64'h00A4_0000_0000_00A4;
  localparam logic [CfgW-1:0] AResetVal = 64'h0CCD_0000_0000_0CCD;
  localparam logic [CfgW-1:0] BResetVal = 64'h3000_0000_0000_3000;

  localparam logic signed [CovW-1:0] OneQ24  = 32'sh0100_0000;
  localparam logic signed [CovW-1:0] CovMax  = 32'sh7FFF_FFFF;
  localparam logic signed [CovW-1:0] CovMin  = 32'sh8000_0000;
  localparam logic [CAlign-1:0]      RndBias = 24'h00_2000;

  typedef struct packed {
    logic       valid;
    logic       outer;
    logic [3:0] step;
  } mgcov_tag_t;

  function automatic logic signed [CoefW-1:0] coef_sel(input logic [CfgW-1:0] regv,
                                                       input logic [1:0] e);
    coef_sel = signed'(regv[{e, 4'b0000} +: CoefW]);
  endfunction

endpackage

### rtl/core/mgarch_covariance_update.sv
// ----------------------------------------------------------------------------
// mgarch_covariance_update
// two-asset garch(1,1) covariance recursion on one shared 16x32 multiplier
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  cfg      | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | in
//  in       | in_valid_i in_ready_o ret_first_i ret_second_i | in
//  out      | out_valid_o out_ready_i cov_r*_o saturated_o   | out
//
//  an item runs 3 outer products and 16 coefficient products through
//  the single multiplier, then a drain state, then the load of the
//  output register; the next beat is taken only back in idle
//  reset loads default coefficients and identity covariance, no clearing pass
//  a stalled output holds the block in its final state until the beat is taken
// ----------------------------------------------------------------------------
module mgarch_covariance_update
  import mgcov_pkg::*;
#(
  parameter int unsigned ASSETS = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgW-1:0]            cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [RetW-1:0]     ret_first_i,
  input  logic signed [RetW-1:0]     ret_second_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [CovW-1:0]     cov_r0c0_o,
  output logic signed [CovW-1:0]     cov_r0c1_o,
  output logic signed [CovW-1:0]     cov_r1c0_o,
  output logic signed [CovW-1:0]     cov_r1c1_o,
  output logic                       saturated_o
);

  localparam int unsigned Dim = (ASSETS > 1) ? 2 : 1;

  typedef enum logic [2:0] {StIdle, StOuter, StMac, StDrain, StDone} state_e;

  state_e                  state_q;
  logic [3:0]              cnt_q;
  mgcov_tag_t              tag_q, issue_tag;
  logic                    clip_q;
  logic                    out_valid_q;
  logic [CfgW-1:0]         c_q, a_q, b_q;
  logic signed [CovW-1:0]  h_q [4];
  logic signed [CovW-1:0]  hn_q [4];
  logic signed [CovW-1:0]  outer_q [3];
  logic signed [CovW-1:0]  out_q [4];
  logic                    out_sat_q;
  logic signed [RetW-1:0]  r0_q, r1_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  logic                    in_acc, out_load;
  logic signed [CoefW-1:0] mul_a;
  logic signed [CovW-1:0]  mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic                    mi, mj;
  logic [1:0]              oidx0, oidx1;
  logic [1:0]              wb_t, wb_e;
  logic signed [AccW-1:0]  acc_base, acc_sum;
  logic [RndW-1:0]         rnd;
  logic                    ovf, keep;
  logic signed [CovW-1:0]  wb_val;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // operand select for the shared multiplier
  assign mi    = cnt_q[3];
  assign mj    = cnt_q[2];
  assign oidx0 = {1'b0, mj};
  assign oidx1 = 2'd1 + {1'b0, mj};

  always_comb begin
    mul_a           = '0;
    mul_b           = '0;
    issue_tag       = '0;
    issue_tag.step  = cnt_q;
    case (state_q)
      StOuter: begin
        issue_tag.valid = 1'b1;
        issue_tag.outer = 1'b1;
        case (cnt_q[1:0])
          2'd0: begin
            mul_a = r0_q;
            mul_b = CovW'(r0_q);
          end
          2'd1: begin
            mul_a = r0_q;
            mul_b = CovW'(r1_q);
          end
          default: begin
            mul_a = r1_q;
            mul_b = CovW'(r1_q);
          end
        endcase
      end
      StMac: begin
        issue_tag.valid = 1'b1;
        case (cnt_q[1:0])
          2'd0: begin
            mul_a = coef_sel(a_q, {mi, 1'b0});
            mul_b = outer_q[oidx0];
          end
          2'd1: begin
            mul_a = coef_sel(a_q, {mi, 1'b1});
            mul_b = outer_q[oidx1];
          end
          2'd2: begin
            mul_a = coef_sel(b_q, {mi, 1'b0});
            mul_b = h_q[{1'b0, mj}];
          end
          default: begin
            mul_a = coef_sel(b_q, {mi, 1'b1});
            mul_b = h_q[{1'b1, mj}];
          end
        endcase
      end
      default: begin
        issue_tag.valid = 1'b0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // accumulate, round half up and saturate
  assign wb_t     = tag_q.step[1:0];
  assign wb_e     = tag_q.step[3:2];
  assign acc_base = (wb_t == 2'd0)
                  ? signed'({(AccW-CAlign)'(coef_sel(c_q, wb_e)), RndBias})
                  : acc_q;
  assign acc_sum  = acc_base + AccW'(prod_q);
  assign rnd      = acc_sum[AccW-1:FracDrop];
  assign ovf      = !((&rnd[RndW-1:CovW-1]) || !(|rnd[RndW-1:CovW-1]));
  assign keep     = (Dim > 1) || (wb_e == 2'd0);
  assign wb_val   = !keep ? '0 : (ovf ? (rnd[RndW-1] ? CovMin : CovMax)
                                      : signed'(rnd[CovW-1:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      tag_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      c_q         <= CResetVal;
      a_q         <= AResetVal;
      b_q         <= BResetVal;
      h_q[0]      <= OneQ24;
      h_q[1]      <= '0;
      h_q[2]      <= '0;
      h_q[3]      <= (Dim > 1) ? OneQ24 : '0;
    end else begin
      tag_q <= issue_tag;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgIdxC: c_q <= cfg_data_i;
          CfgIdxA: a_q <= cfg_data_i;
          CfgIdxB: b_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      if (tag_q.valid && !tag_q.outer && (wb_t == 2'd3) && keep && ovf) begin
        clip_q <= 1'b1;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            clip_q  <= 1'b0;
            cnt_q   <= '0;
            state_q <= StOuter;
          end
        end
        StOuter: begin
          if (cnt_q == 4'd2) begin
            cnt_q   <= '0;
            state_q <= StMac;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        StMac: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          state_q <= StDone;
        end
        StDone: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            h_q         <= hn_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_acc) begin
      r0_q <= ret_first_i;
      r1_q <= (Dim > 1) ? ret_second_i : '0;
    end
    if (tag_q.valid) begin
      if (tag_q.outer) begin
        outer_q[tag_q.step[1:0]] <= prod_q[CovW-1:0];
      end else begin
        acc_q <= acc_sum;
        if (wb_t == 2'd3) begin
          hn_q[wb_e] <= wb_val;
        end
      end
    end
    if (out_load) begin
      out_q     <= h_q;
      out_sat_q <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cov_r0c0_o  = out_q[0];
  assign cov_r0c1_o  = out_q[1];
  assign cov_r1c0_o  = out_q[2];
  assign cov_r1c1_o  = out_q[3];
  assign saturated_o = out_sat_q;

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while sequencer busy");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StDone))
    else $error("result raised outside final state");

  a_tag_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q.valid |-> (state_q == StOuter || state_q == StMac || state_q == StDrain))
    else $error("product written back outside compute");

  a_single_asset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (Dim == 1) |-> (h_q[1] == '0 && h_q[2] == '0 && h_q[3] == '0))
    else $error("unused covariance entries not zero");

endmodule
